// ===== hw/rtl/ae_pkg.sv =====
// Shared constants and widths for the arithmetic encoder.
package ae_pkg;

  localparam int STATE_BITS_DEF = 32;  // default interval width
  localparam int FREQ_W         = 31;  // cumulative frequency field width
  localparam int PEND_W         = 32;  // pending count / follow count width

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

endpackage

// ===== hw/rtl/ae_if.sv =====
// Request and result channel interfaces of the arithmetic encoder.
interface ae_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [ae_pkg::FREQ_W-1:0]     cum_low;
  logic [ae_pkg::FREQ_W-1:0]     cum_high;
  logic [ae_pkg::FREQ_W-1:0]     total_count;

  modport source (output valid, cmd, cum_low, cum_high, total_count, input ready);
  modport sink   (input valid, cmd, cum_low, cum_high, total_count, output ready);
endinterface

interface ae_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_bit;
  logic [ae_pkg::PEND_W-1:0]     follow_count;
  logic                          is_last;
  logic                          error;

  modport source (output valid, out_bit, follow_count, is_last, error, input ready);
  modport sink   (input valid, out_bit, follow_count, is_last, error, output ready);
endinterface

// ===== hw/rtl/arithmetic_encoder.sv =====
// Top level of the binary arithmetic encoder.
// Usage:
//  in_chan (valid/ready) takes one request: cmd = encode with cum_low,
//  cum_high and total_count, or cmd = finish. out_chan (valid/ready) gives
//  results: out_bit, follow_count (complemented bits that follow it),
//  is_last on the final result of a request, and error for a rejected one.
//  An encode request narrows the interval with two bit-serial dividers that
//  run side by side; then one shifted-out bit per cycle (up to STATE_BITS
//  results, each also waiting for the output register), then the underflow
//  deletions, after which the encoder is back in idle. Finish and error
//  requests load their single result at once. One request is worked on at
//  a time; in_chan.ready is high in the idle state while the output
//  register is free or being drained.
//  A stalled receiver holds the output register and freezes the shift loop.
//  Reset (rst_n low, synchronous) sets low to zero, high to all ones,
//  the pending count to zero and drops any result not yet taken.
module arithmetic_encoder #(
  parameter int STATE_BITS = ae_pkg::STATE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ae_in_if.sink          in_chan,
  ae_out_if.source       out_chan
);

  localparam int SB = STATE_BITS;
  localparam int FW = ae_pkg::FREQ_W;
  localparam int PW = ae_pkg::PEND_W;
  localparam int NW = $clog2(SB + 1);
  localparam logic [FW:0] MAX_TOT = (FW+1)'((64'd1 << (SB - 2)) + 64'd2);
  localparam logic [NW-1:0] N_MAX = NW'(SB);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_UFLOW = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [SB-1:0]   low_r, low_nxt;
  logic [SB-1:0]   high_r, high_nxt;
  logic [PW-1:0]   pend_r, pend_nxt;
  logic [NW-1:0]   n_r, n_nxt;

  logic            ov_r, ov_nxt;
  logic            obit_r, obit_nxt;
  logic [PW-1:0]   ofol_r, ofol_nxt;
  logic            olast_r, olast_nxt;
  logic            oerr_r, oerr_nxt;

  logic            out_free, in_acc, req_ok, div_start, done_lo, done_hi;
  logic [SB:0]     range, q_lo, q_hi;
  logic [PW-1:0]   pend_inc;
  logic            agree, agree_next, uflow;

  assign out_free  = !ov_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_chan.valid && in_chan.ready;

  // valid iff cum_low < cum_high <= total_count <= quarter range + 2
  assign req_ok = (in_chan.cum_low < in_chan.cum_high) &&
                  (in_chan.cum_high <= in_chan.total_count) &&
                  ({1'b0, in_chan.total_count} <= MAX_TOT);
  assign div_start = in_acc && (in_chan.cmd == ae_pkg::CMD_ENCODE) && req_ok;
  assign range     = {1'b0, high_r} - {1'b0, low_r} + (SB+1)'(1);
  assign pend_inc  = (&pend_r) ? pend_r : pend_r + PW'(1);

  assign agree      = (low_r[SB-1] == high_r[SB-1]);
  assign agree_next = (low_r[SB-2] == high_r[SB-2]);
  assign uflow      = low_r[SB-2] & ~high_r[SB-2];

  ae_divser #(.STATE_BITS(SB)) u_div_lo (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .mult(in_chan.cum_low), .divisor(in_chan.total_count), .range(range),
    .quo(q_lo), .done(done_lo)
  );

  ae_divser #(.STATE_BITS(SB)) u_div_hi (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .mult(in_chan.cum_high), .divisor(in_chan.total_count), .range(range),
    .quo(q_hi), .done(done_hi)
  );

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    pend_nxt  = pend_r;
    n_nxt     = n_r;
    ov_nxt    = ov_r && !out_chan.ready;
    obit_nxt  = obit_r;
    ofol_nxt  = ofol_r;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.cmd == ae_pkg::CMD_FINISH) begin
            // final bit is 0 when low sits in the bottom quarter
            ov_nxt    = 1'b1;
            obit_nxt  = low_r[SB-1] | low_r[SB-2];
            ofol_nxt  = pend_inc;
            olast_nxt = 1'b1;
            oerr_nxt  = 1'b0;
            low_nxt   = '0;
            high_nxt  = '1;
            pend_nxt  = '0;
          end else if (!req_ok) begin
            ov_nxt    = 1'b1;
            obit_nxt  = 1'b0;
            ofol_nxt  = '0;
            olast_nxt = 1'b1;
            oerr_nxt  = 1'b1;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (done_lo) begin
          low_nxt   = low_r + q_lo[SB-1:0];
          high_nxt  = low_r + q_hi[SB-1:0] - SB'(1);
          n_nxt     = '0;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (agree && (n_r != N_MAX)) begin
          if (out_free) begin
            ov_nxt    = 1'b1;
            obit_nxt  = low_r[SB-1];
            ofol_nxt  = pend_r;
            olast_nxt = !(agree_next && (n_r + NW'(1) != N_MAX));
            oerr_nxt  = 1'b0;
            pend_nxt  = '0;
            n_nxt     = n_r + NW'(1);
            low_nxt   = {low_r[SB-2:0], 1'b0};
            high_nxt  = {high_r[SB-2:0], 1'b1};
          end
        end else begin
          state_nxt = ST_UFLOW;
        end
      end
      ST_UFLOW: begin
        // low 01.., high 10..: drop the second bit, one more pending bit
        if (uflow) begin
          pend_nxt = pend_inc;
          low_nxt  = {~low_r[SB-2], low_r[SB-3:0], 1'b0};
          high_nxt = {1'b1, high_r[SB-3:0], 1'b1};
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      low_r   <= '0;
      high_r  <= '1;
      pend_r  <= '0;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      pend_r  <= pend_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obit_r  <= obit_nxt;
    ofol_r  <= ofol_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.out_bit      = obit_r;
  assign out_chan.follow_count = ofol_r;
  assign out_chan.is_last      = olast_r;
  assign out_chan.error        = oerr_r;

`ifndef SYNTHESIS
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    done_lo == done_hi)
    else $error("divider done flags out of step");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oerr_r |-> olast_r && !obit_r && (ofol_r == '0))
    else $error("error result malformed");

  a_finish_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_chan.cmd == ae_pkg::CMD_FINISH) |=>
      (low_r == '0) && (&high_r) && (pend_r == '0))
    else $error("finish did not restore the interval");

  a_pend_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (&pend_r) && (state_r == ST_UFLOW) |=> (&pend_r) || (pend_r == '0))
    else $error("pending count wrapped");
`endif

endmodule

// ===== hw/rtl/ae_divser.sv =====
// Bit-serial floor((mult * range) / divisor), one range bit per cycle.
module ae_divser #(
  parameter int STATE_BITS = ae_pkg::STATE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ae_pkg::FREQ_W-1:0] mult,
  input  logic [ae_pkg::FREQ_W-1:0] divisor,
  input  logic [STATE_BITS:0]       range,
  output logic [STATE_BITS:0]       quo,
  output logic                      done
);

  localparam int FW  = ae_pkg::FREQ_W;
  localparam int CW  = $clog2(STATE_BITS + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(STATE_BITS);

  logic [STATE_BITS:0] rng_r, rng_nxt;
  logic [STATE_BITS:0] quo_r, quo_nxt;
  logic [FW-1:0]       mult_r, div_r;
  logic [FW-1:0]       rem_r, rem_nxt;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;
  logic [FW+1:0]       part, twice_div;

  // rem < div and mult <= div, so 2*rem + mult < 3*div: digit is 0, 1 or 2
  always_comb begin
    part      = {1'b0, rem_r, 1'b0} + (rng_r[STATE_BITS] ? {2'b00, mult_r} : '0);
    twice_div = {1'b0, div_r, 1'b0};
    rng_nxt   = {rng_r[STATE_BITS-1:0], 1'b0};
    if (part >= twice_div) begin
      rem_nxt = FW'(part - twice_div);
      quo_nxt = {quo_r[STATE_BITS-1:0], 1'b0} + (STATE_BITS+1)'(2);
    end else if (part >= {2'b00, div_r}) begin
      rem_nxt = FW'(part - {2'b00, div_r});
      quo_nxt = {quo_r[STATE_BITS-1:0], 1'b0} + (STATE_BITS+1)'(1);
    end else begin
      rem_nxt = FW'(part);
      quo_nxt = {quo_r[STATE_BITS-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + CW'(1);
      busy_r <= (cnt_r != LAST_STEP);
      done_r <= (cnt_r == LAST_STEP);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rng_r  <= range;
      mult_r <= mult;
      div_r  <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rng_r <= rng_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule
